>>> hw/rtl/set_mean_stddev_cv_stats_defines.svh
// assertion macros for the set statistics block
// used by set_mean_stddev_cv_stats.sv, expects clk and rst_n in scope
`ifndef SET_MEAN_STDDEV_CV_STATS_DEFINES_SVH
`define SET_MEAN_STDDEV_CV_STATS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SMSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set stats check failed");

// next-cycle implication, checked outside reset
`define SMSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set stats check failed");

`endif

>>> hw/rtl/smsc_pkg.sv
// shared constants, types and codes for the set statistics block
// no dependencies
`default_nettype none
package smsc_pkg;

  localparam int SET_DEPTH  = 64;
  localparam int ADDR_W     = $clog2(SET_DEPTH);
  localparam int CNT_W      = $clog2(SET_DEPTH + 1);
  localparam int SUM_W      = 32 + ADDR_W;
  localparam int ACC_W      = 64 + ADDR_W;
  localparam int DIV_N_W    = ACC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);
  localparam int VCNT_W     = 7;
  localparam int OUT_DATA_W = 168;
  localparam int OUT_USER_W = 2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_MEAN_W,
    ST_DEV,
    ST_DEV_W,
    ST_VAR,
    ST_VAR_W,
    ST_SQRT,
    ST_SQRT_W,
    ST_CV,
    ST_CV_W,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_CV
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_t div_op;
    logic    dev_start;
    logic    sqrt_start;
    logic    result_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic dev_busy;
    logic sqrt_busy;
    logic out_hold;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/smsc_ctrl.sv
// sequencer for load, mean, deviation pass, variance, root and cv steps
// depends on smsc_pkg
`default_nettype none
module smsc_ctrl
  import smsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire logic    in_tlast,
  output logic         in_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.div_op      = DIV_MEAN;
    in_tready       = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_MEAN;
        state_nxt     = ST_MEAN_W;
      end
      ST_MEAN_W: if (status.div_done) begin
        state_nxt = ST_DEV;
      end
      ST_DEV: begin
        cmd.dev_start = 1'b1;
        state_nxt     = ST_DEV_W;
      end
      ST_DEV_W: if (!status.dev_busy) begin
        state_nxt = ST_VAR;
      end
      ST_VAR: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_VAR;
        state_nxt     = ST_VAR_W;
      end
      ST_VAR_W: if (status.div_done) begin
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_SQRT_W;
      end
      ST_SQRT_W: if (!status.sqrt_busy) begin
        state_nxt = ST_CV;
      end
      ST_CV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_CV;
        state_nxt     = ST_CV_W;
      end
      ST_CV_W: if (status.div_done) begin
        state_nxt = ST_DONE;
      end
      ST_DONE: if (!status.out_hold) begin
        cmd.result_load = 1'b1;
        state_nxt       = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/smsc_dp.sv
// datapath: value memory, running sums, deviation pipe, shared divider,
// square root unit and result register; depends on smsc_pkg
`default_nettype none
module smsc_dp
  import smsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  input  wire logic [31:0]           sample,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser
);

  // set accumulation
  logic [31:0]              mem [SET_DEPTH];
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [31:0]       min_r, max_r;
  logic                     ovf_r;
  logic                     full;
  logic signed [31:0]       smp;

  assign smp  = sample;
  assign full = (cnt_r == CNT_W'(SET_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[cnt_r[ADDR_W-1:0]] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= 32'sh7FFF_FFFF;
      max_r <= 32'sh8000_0000;
      ovf_r <= 1'b0;
    end else if (cmd.result_load) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= 32'sh7FFF_FFFF;
      max_r <= 32'sh8000_0000;
      ovf_r <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        sum_r <= sum_r + {{(SUM_W-32){smp[31]}}, smp};
        if (smp < min_r) min_r <= smp;
        if (smp > max_r) max_r <= smp;
      end
    end
  end

  // intermediate results
  logic signed [31:0] mean_r;
  logic [31:0]        absmean;
  logic [63:0]        var_r;
  logic [31:0]        cv_r;
  logic [31:0]        root_r;
  logic [30:0]        sd;

  assign absmean = mean_r[31] ? 32'(-mean_r) : mean_r;
  assign sd      = (root_r[31]) ? 31'h7FFF_FFFF : root_r[30:0];

  // deviation pass: address, read, abs difference, square, accumulate
  logic [ADDR_W-1:0] rd_addr_r;
  logic [ADDR_W-1:0] last_addr;
  logic              issue_r, v1_r, v2_r, v3_r;
  logic [31:0]       rdata_r;
  logic [32:0]       diff;
  logic [31:0]       absd_r;
  logic [63:0]       sq_r;
  logic [ACC_W-1:0]  acc_r;

  assign last_addr = ADDR_W'(cnt_r - CNT_W'(1));
  assign diff      = {rdata_r[31], rdata_r} - {mean_r[31], mean_r};

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr_r];
    absd_r  <= diff[32] ? 32'(-diff) : diff[31:0];
    sq_r    <= absd_r * absd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      rd_addr_r <= '0;
      acc_r     <= '0;
    end else begin
      v1_r <= issue_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.dev_start) begin
        issue_r   <= 1'b1;
        rd_addr_r <= '0;
        acc_r     <= '0;
      end else begin
        if (issue_r) begin
          rd_addr_r <= rd_addr_r + ADDR_W'(1);
          if (rd_addr_r == last_addr) issue_r <= 1'b0;
        end
        if (v3_r) acc_r <= acc_r + ACC_W'(sq_r);
      end
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [DIV_N_W-1:0]   num_r;
  logic [31:0]          rem_r, dvs_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                 dbusy_r, ddone_r;
  div_op_t              dop_r;
  logic [32:0]          dt;
  logic [33:0]          dsub;
  logic [SUM_W-1:0]     abssum;

  assign dt     = {rem_r, num_r[DIV_N_W-1]};
  assign dsub   = {1'b0, dt} - {2'b00, dvs_r};
  assign abssum = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      dcnt_r  <= '0;
      dop_r   <= DIV_MEAN;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= '0;
        dop_r   <= cmd.div_op;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
          dbusy_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      case (cmd.div_op)
        DIV_MEAN: begin
          num_r <= DIV_N_W'(abssum);
          dvs_r <= 32'(cnt_r);
        end
        DIV_VAR: begin
          num_r <= DIV_N_W'(acc_r);
          dvs_r <= 32'(cnt_r);
        end
        DIV_CV: begin
          num_r <= DIV_N_W'({sd, 16'h0000});
          dvs_r <= absmean;
        end
        default: begin
          num_r <= '0;
          dvs_r <= 32'd1;
        end
      endcase
    end else if (dbusy_r) begin
      if (!dsub[33]) begin
        rem_r <= dsub[31:0];
        num_r <= {num_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_r <= dt[31:0];
        num_r <= {num_r[DIV_N_W-2:0], 1'b0};
      end
    end
    if (ddone_r) begin
      case (dop_r)
        DIV_MEAN: mean_r <= sum_r[SUM_W-1] ? 32'(-num_r[31:0]) : num_r[31:0];
        DIV_VAR:  var_r  <= (|num_r[DIV_N_W-1:64]) ? '1 : num_r[63:0];
        DIV_CV:   cv_r   <= (|num_r[DIV_N_W-1:32]) ? '1 : num_r[31:0];
        default:  cv_r   <= cv_r;
      endcase
    end
  end

  // digit-by-digit square root, one result bit per cycle
  logic [63:0] xs_r;
  logic [33:0] srem_r;
  logic [4:0]  scnt_r;
  logic        sbusy_r;
  logic [34:0] srem2, strial, ssub;

  assign srem2  = {srem_r[32:0], xs_r[63:62]};
  assign strial = {1'b0, root_r, 2'b01};
  assign ssub   = srem2 - strial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      scnt_r  <= '0;
    end else if (cmd.sqrt_start) begin
      sbusy_r <= 1'b1;
      scnt_r  <= '0;
    end else if (sbusy_r) begin
      scnt_r <= scnt_r + 5'd1;
      if (scnt_r == 5'd31) sbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      xs_r   <= var_r;
      srem_r <= '0;
      root_r <= '0;
    end else if (sbusy_r) begin
      xs_r <= {xs_r[61:0], 2'b00};
      if (srem2 >= strial) begin
        srem_r <= ssub[33:0];
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        srem_r <= srem2[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  // result register
  logic                   ovalid_r;
  logic [OUT_DATA_W-1:0]  odata_r;
  logic [OUT_USER_W-1:0]  ouser_r;
  logic                   mzero;

  assign mzero = (mean_r == 32'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.result_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      odata_r <= {2'b00, VCNT_W'(cnt_r), (mzero ? 32'd0 : cv_r), max_r, min_r, sd, mean_r};
      ouser_r <= {ovf_r, (mzero && (sd != 31'd0))};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  assign status.div_done  = ddone_r;
  assign status.dev_busy  = issue_r | v1_r | v2_r | v3_r;
  assign status.sqrt_busy = sbusy_r;
  assign status.out_hold  = ovalid_r && !out_tready;

endmodule
`default_nettype wire

>>> hw/rtl/set_mean_stddev_cv_stats.sv
// set statistics: min, max, mean, stddev and cv of a set of Q16.16 values
// loads one item per cycle while in_tready is high; after the last item, the steps are
// the mean division on the 70-step shared divider, the memory pass through a 3-stage
// pipe, the variance division, the 32-step root and the cv division
// no item is taken during the computation; a held result delays its successor
// synchronous active-low reset clears the set; the value memory is not cleared
`default_nettype none
`include "set_mean_stddev_cv_stats_defines.svh"
module set_mean_stddev_cv_stats
  import smsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input item
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [31:0]           in_tdata,   // sample
  input  wire logic                  in_tlast,   // last_sample
  // result item
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // mean_out[31:0], stddev_out[62:32], min_out[94:63], max_out[126:95],
  // cv_out[158:127], value_count[165:159], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // cv_infinite[0], set_overflow[1]
  output logic [OUT_USER_W-1:0]      out_tuser
);

  cmd_t    cmd;
  status_t status;

  // sequencer: holds the phase, issues one-cycle start pulses
  smsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // all storage and arithmetic
  smsc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .sample     (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // infinite cv only with a zero mean and a nonzero stddev
  `SMSC_ASSERT_IMP(a_cv_inf, out_tvalid && out_tuser[0], (out_tdata[31:0] == 32'd0) && (out_tdata[62:32] != 31'd0))
  // every result covers at least one value
  `SMSC_ASSERT_IMP(a_count, out_tvalid, out_tdata[165:159] != 7'd0)
  // minimum never exceeds maximum
  `SMSC_ASSERT_IMP(a_minmax, out_tvalid, $signed(out_tdata[94:63]) <= $signed(out_tdata[126:95]))

endmodule
`default_nettype wire
